FILE: rtl/rpl_pkg.sv
package rpl_pkg;

    localparam int STAMP_W        = 32;
    localparam int COUNT_W        = 32;
    localparam int ROM_SIZE_RESET = 32768;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_SCAN,
        ST_FILL
    } t_state;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic is_reload;
        logic oor;
        logic hit;
        logic has_free;
        logic scan_last;
        logic out_free;
    } t_dp_stat;

endpackage

FILE: rtl/rom_page_lru_cache.sv
// Page cache tag and replacement controller.
// Request channel: i_valid/o_ready with i_op (0 read, 1 reload) and i_address.
// A request is taken whenever the controller is idle, even while an earlier
// result still waits in the output register.
// Result channel: o_valid/i_ready with one result per request, held in an
// output register until taken.
// Config channel: i_cfg_valid/o_cfg_ready with i_rom_size_bytes; always ready,
// write only while no request is in flight.
// Flow: a hit, an out-of-range read, a reload, or a miss that finds a free
// slot commits its result from the look-up state, and the controller then
// returns to idle for the next request. A miss on a full cache walks the slot
// stamps one slot per cycle for the victim in the scan state, then commits
// from the fill state before it returns to idle.
// A stalled receiver holds the result; the next request may be accepted and
// looked up, but it commits only once the output register frees.
// Reset empties all slots, unpins slot 0, zeroes the use clock and counters,
// and sets the ROM size to 32768. No clearing pass is needed.
module rom_page_lru_cache #(
    parameter int SLOTS         = 16,
    parameter int PAGE_BYTES    = 16384,
    parameter int MAX_ROM_BYTES = 4194304,
    localparam int SLOT_W = $clog2(SLOTS),
    localparam int PO_W   = $clog2(PAGE_BYTES),
    localparam int ADDR_W = $clog2(MAX_ROM_BYTES),
    localparam int PAGE_W = ADDR_W - PO_W,
    localparam int SIZE_W = ADDR_W + 1,
    localparam int FB_W   = PO_W + 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_op,
    input  logic [ADDR_W-1:0]           i_address,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [SIZE_W-1:0]           i_rom_size_bytes,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_out_of_range,
    output logic                        o_hit,
    output logic [SLOT_W-1:0]           o_slot,
    output logic [PO_W-1:0]             o_page_offset,
    output logic                        o_fill_request,
    output logic [PAGE_W-1:0]           o_fill_page,
    output logic [FB_W-1:0]             o_fill_valid_bytes,
    output logic [rpl_pkg::COUNT_W-1:0] o_hit_total,
    output logic [rpl_pkg::COUNT_W-1:0] o_miss_total
);
    import rpl_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    rpl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    rpl_dp #(
        .SLOTS         (SLOTS),
        .PAGE_BYTES    (PAGE_BYTES),
        .MAX_ROM_BYTES (MAX_ROM_BYTES)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_op               (i_op),
        .i_address          (i_address),
        .i_cfg_valid        (i_cfg_valid),
        .i_rom_size_bytes   (i_rom_size_bytes),
        .i_ready            (i_ready),
        .o_valid            (o_valid),
        .o_out_of_range     (o_out_of_range),
        .o_hit              (o_hit),
        .o_slot             (o_slot),
        .o_page_offset      (o_page_offset),
        .o_fill_request     (o_fill_request),
        .o_fill_page        (o_fill_page),
        .o_fill_valid_bytes (o_fill_valid_bytes),
        .o_hit_total        (o_hit_total),
        .o_miss_total       (o_miss_total)
    );

    a_commit_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> stat.out_free)
        else $error("result committed over a pending result");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("request taken while another is in flight");

    a_hit_no_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_hit && o_fill_request))
        else $error("hit result carries a fill request");

    a_oor_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_of_range) |-> (!o_hit && !o_fill_request && o_slot == '0))
        else $error("out-of-range result touches a slot");

endmodule

FILE: rtl/rpl_ctrl.sv
module rpl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  rpl_pkg::t_dp_stat i_stat,
    output rpl_pkg::t_dp_cmd  o_cmd
);
    import rpl_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   fast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign fast = i_stat.is_reload || i_stat.oor || i_stat.hit || i_stat.has_free;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (fast) begin
                    if (i_stat.out_free) begin
                        o_cmd.commit = 1'b1;
                        n_state      = ST_IDLE;
                    end
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = ST_FILL;
                end
            end
            ST_FILL: begin
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

FILE: rtl/rpl_dp.sv
module rpl_dp #(
    parameter int SLOTS         = 16,
    parameter int PAGE_BYTES    = 16384,
    parameter int MAX_ROM_BYTES = 4194304,
    localparam int SLOT_W = $clog2(SLOTS),
    localparam int PO_W   = $clog2(PAGE_BYTES),
    localparam int ADDR_W = $clog2(MAX_ROM_BYTES),
    localparam int PAGE_W = ADDR_W - PO_W,
    localparam int SIZE_W = ADDR_W + 1,
    localparam int FB_W   = PO_W + 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rpl_pkg::t_dp_cmd           i_cmd,
    output rpl_pkg::t_dp_stat          o_stat,
    input  logic                       i_op,
    input  logic [ADDR_W-1:0]          i_address,
    input  logic                       i_cfg_valid,
    input  logic [SIZE_W-1:0]          i_rom_size_bytes,
    input  logic                       i_ready,
    output logic                       o_valid,
    output logic                       o_out_of_range,
    output logic                       o_hit,
    output logic [SLOT_W-1:0]          o_slot,
    output logic [PO_W-1:0]            o_page_offset,
    output logic                       o_fill_request,
    output logic [PAGE_W-1:0]          o_fill_page,
    output logic [FB_W-1:0]            o_fill_valid_bytes,
    output logic [rpl_pkg::COUNT_W-1:0] o_hit_total,
    output logic [rpl_pkg::COUNT_W-1:0] o_miss_total
);
    import rpl_pkg::*;

    logic                r_op;
    logic [ADDR_W-1:0]   r_addr;
    logic [SIZE_W-1:0]   r_rom_size;
    logic [PAGE_W-1:0]   r_slot_page  [SLOTS];
    logic [STAMP_W-1:0]  r_slot_stamp [SLOTS];
    logic [SLOTS-1:0]    r_slot_valid;
    logic                r_pinned;
    logic [STAMP_W-1:0]  r_use_clock;
    logic [COUNT_W-1:0]  r_hit_cnt;
    logic [COUNT_W-1:0]  r_miss_cnt;
    logic [SLOT_W-1:0]   r_scan_idx;
    logic [SLOT_W-1:0]   r_best;
    logic [STAMP_W-1:0]  r_best_stamp;
    logic                r_best_found;

    logic                r_out_valid;
    logic                r_oor;
    logic                r_hit;
    logic [SLOT_W-1:0]   r_slot;
    logic [PO_W-1:0]     r_offset;
    logic                r_freq;
    logic [PAGE_W-1:0]   r_fpage;
    logic [FB_W-1:0]     r_fbytes;
    logic [COUNT_W-1:0]  r_hit_total;
    logic [COUNT_W-1:0]  r_miss_total;

    logic [PAGE_W-1:0]   page;
    logic [PO_W-1:0]     offset;
    logic                oor;
    logic                hit_any;
    logic [SLOT_W-1:0]   hit_idx;
    logic                free_any;
    logic [SLOT_W-1:0]   free_idx;
    logic [SLOT_W-1:0]   victim;
    logic [STAMP_W-1:0]  new_clock;
    logic [STAMP_W-1:0]  cand_stamp;
    logic                take;
    logic                is_miss;
    logic [PAGE_W-1:0]   fill_pg;
    logic [PAGE_W:0]     rom_hi;
    logic [FB_W-1:0]     valid_bytes;

    assign page      = r_addr[ADDR_W-1:PO_W];
    assign offset    = r_addr[PO_W-1:0];
    assign oor       = {1'b0, r_addr} >= r_rom_size;
    assign new_clock = r_use_clock + STAMP_W'(1);

    always_comb begin
        hit_any  = 1'b0;
        hit_idx  = '0;
        free_any = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (r_slot_valid[i] && r_slot_page[i] == page) begin
                hit_any = 1'b1;
                hit_idx = SLOT_W'(i);
            end
            if (!r_slot_valid[i]) begin
                free_any = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    assign victim  = hit_any ? hit_idx : (free_any ? free_idx : r_best);
    assign is_miss = !r_op && !oor && !hit_any;

    assign cand_stamp = r_slot_stamp[r_scan_idx];
    assign take = !((r_scan_idx == '0) && r_pinned) &&
                  (!r_best_found || cand_stamp < r_best_stamp);

    assign fill_pg = r_op ? '0 : page;
    assign rom_hi  = r_rom_size[SIZE_W-1:PO_W];

    always_comb begin
        if ({1'b0, fill_pg} < rom_hi) begin
            valid_bytes = FB_W'(PAGE_BYTES);
        end else if ({1'b0, fill_pg} == rom_hi) begin
            valid_bytes = {1'b0, r_rom_size[PO_W-1:0]};
        end else begin
            valid_bytes = '0;
        end
    end

    always_comb begin
        o_stat.is_reload = r_op;
        o_stat.oor       = oor;
        o_stat.hit       = hit_any;
        o_stat.has_free  = free_any;
        o_stat.scan_last = r_scan_idx == SLOT_W'(SLOTS - 1);
        o_stat.out_free  = !r_out_valid || i_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_size   <= SIZE_W'(ROM_SIZE_RESET);
            r_slot_valid <= '0;
            r_pinned     <= 1'b0;
            r_use_clock  <= '0;
            r_hit_cnt    <= '0;
            r_miss_cnt   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_rom_size <= i_rom_size_bytes;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.commit) begin
                if (r_op) begin
                    r_slot_valid <= SLOTS'(1);
                    r_pinned     <= 1'b1;
                    r_use_clock  <= STAMP_W'(1);
                    r_hit_cnt    <= '0;
                    r_miss_cnt   <= '0;
                end else if (!oor) begin
                    r_slot_valid[victim] <= 1'b1;
                    r_use_clock          <= new_clock;
                    if (hit_any) begin
                        r_hit_cnt <= r_hit_cnt + COUNT_W'(1);
                    end else begin
                        r_miss_cnt <= r_miss_cnt + COUNT_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_op;
            r_addr <= i_address;
        end
        if (i_cmd.scan_start) begin
            r_scan_idx   <= '0;
            r_best_found <= 1'b0;
        end else if (i_cmd.scan_step) begin
            r_scan_idx <= r_scan_idx + SLOT_W'(1);
            if (take) begin
                r_best       <= r_scan_idx;
                r_best_stamp <= cand_stamp;
                r_best_found <= 1'b1;
            end
        end
        if (i_cmd.commit) begin
            if (r_op) begin
                r_slot_page[0]  <= '0;
                r_slot_stamp[0] <= STAMP_W'(1);
            end else if (!oor) begin
                r_slot_page[victim]  <= page;
                r_slot_stamp[victim] <= new_clock;
            end
            r_oor    <= !r_op && oor;
            r_hit    <= !r_op && !oor && hit_any;
            r_slot   <= (r_op || oor) ? '0 : victim;
            r_offset <= (r_op || oor) ? '0 : offset;
            r_freq   <= r_op || is_miss;
            r_fpage  <= is_miss ? page : '0;
            r_fbytes <= (r_op || is_miss) ? valid_bytes : '0;
            if (r_op) begin
                r_hit_total  <= '0;
                r_miss_total <= '0;
            end else if (oor) begin
                r_hit_total  <= r_hit_cnt;
                r_miss_total <= r_miss_cnt;
            end else if (hit_any) begin
                r_hit_total  <= r_hit_cnt + COUNT_W'(1);
                r_miss_total <= r_miss_cnt;
            end else begin
                r_hit_total  <= r_hit_cnt;
                r_miss_total <= r_miss_cnt + COUNT_W'(1);
            end
        end
    end

    assign o_valid            = r_out_valid;
    assign o_out_of_range     = r_oor;
    assign o_hit              = r_hit;
    assign o_slot             = r_slot;
    assign o_page_offset      = r_offset;
    assign o_fill_request     = r_freq;
    assign o_fill_page        = r_fpage;
    assign o_fill_valid_bytes = r_fbytes;
    assign o_hit_total        = r_hit_total;
    assign o_miss_total       = r_miss_total;

endmodule

FILE: dv/rom_page_lru_cache_test.sv
module rom_page_lru_cache_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rpl_pkg::*;

    localparam int SLOTS      = 16;
    localparam int PAGE_BYTES = 16384;
    localparam int SETTLE     = SLOTS + 8;

    typedef enum bit {
        OP_READ   = 1'b0,
        OP_RELOAD = 1'b1
    } t_op;

    typedef struct {
        t_op       op;
        bit [21:0] addr;
    } t_access;

    typedef struct {
        bit               oor;
        bit               hit;
        bit [3:0]         slot;
        bit [13:0]        offs;
        bit               fill;
        bit [7:0]         fill_page;
        bit [14:0]        fill_bytes;
        bit [COUNT_W-1:0] hits;
        bit [COUNT_W-1:0] misses;
    } t_lookup;

    logic                i_clk            = 1'b0;
    logic                i_rst_n          = 1'b0;
    logic                i_valid          = 1'b0;
    logic                o_ready;
    logic                i_op             = 1'b0;
    logic [21:0]         i_address        = '0;
    logic                i_cfg_valid      = 1'b0;
    logic                o_cfg_ready;
    logic [22:0]         i_rom_size_bytes = '0;
    logic                o_valid;
    logic                i_ready          = 1'b0;
    logic                o_out_of_range;
    logic                o_hit;
    logic [3:0]          o_slot;
    logic [13:0]         o_page_offset;
    logic                o_fill_request;
    logic [7:0]          o_fill_page;
    logic [14:0]         o_fill_valid_bytes;
    logic [COUNT_W-1:0]  o_hit_total;
    logic [COUNT_W-1:0]  o_miss_total;

    rom_page_lru_cache dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_op               (i_op),
        .i_address          (i_address),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_rom_size_bytes   (i_rom_size_bytes),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_out_of_range     (o_out_of_range),
        .o_hit              (o_hit),
        .o_slot             (o_slot),
        .o_page_offset      (o_page_offset),
        .o_fill_request     (o_fill_request),
        .o_fill_page        (o_fill_page),
        .o_fill_valid_bytes (o_fill_valid_bytes),
        .o_hit_total        (o_hit_total),
        .o_miss_total       (o_miss_total)
    );

    // cache image
    bit [7:0]         page_of   [SLOTS];
    bit               resident  [SLOTS];
    bit [STAMP_W-1:0] stamp     [SLOTS];
    bit               pin_first = 1'b0;
    bit [STAMP_W-1:0] use_clk   = '0;
    bit [COUNT_W-1:0] hit_cnt   = '0;
    bit [COUNT_W-1:0] miss_cnt  = '0;
    bit [22:0]        rom_size  = 23'(ROM_SIZE_RESET);

    t_access pending_reqs [$];
    t_lookup expected_lookups [$];

    int unsigned n_sent     = 0;
    int unsigned n_taken    = 0;
    int unsigned n_errors   = 0;
    int unsigned send_wait  = 0;
    int unsigned take_wait  = 0;
    bit          calm       = 1'b1;
    bit          req_taken  = 1'b0;
    bit          res_taken  = 1'b0;
    bit          cfg_taken  = 1'b0;
    bit [22:0]   plan_size  = '0;
    int unsigned ws_base    = 0;

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            page_of[i]  = '0;
            resident[i] = 1'b0;
            stamp[i]    = '0;
        end
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    task automatic report(string msg);
        n_errors++;
        if (n_errors <= 100)
            $display("error at %0t: %s", $realtime, msg);
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    function automatic int unsigned draw_gap();
        if (calm)
            return 0;
        return $urandom_range(0, 16);
    endfunction

    function automatic bit [14:0] bytes_in_page(bit [7:0] pg);
        bit [31:0] start;
        bit [31:0] left;
        start = 32'(pg) * PAGE_BYTES;
        if (start >= 32'(rom_size))
            return '0;
        left = 32'(rom_size) - start;
        if (left > PAGE_BYTES)
            left = PAGE_BYTES;
        return 15'(left);
    endfunction

    function automatic int unsigned pick_victim();
        int unsigned best;
        bit          found;
        best  = 0;
        found = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            if (!resident[i])
                return i;
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (i == 0 && pin_first)
                continue;
            if (!found || stamp[i] < stamp[best]) begin
                best  = i;
                found = 1'b1;
            end
        end
        return best;
    endfunction

    function automatic t_lookup lookup_page(t_op op, bit [21:0] addr);
        t_lookup     r;
        bit [7:0]    pg;
        bit          found;
        int unsigned s;
        r     = '{default: '0};
        pg    = addr[21:14];
        found = 1'b0;
        s     = 0;
        if (op == OP_RELOAD) begin
            for (int i = 0; i < SLOTS; i++) begin
                page_of[i]  = '0;
                resident[i] = 1'b0;
                stamp[i]    = '0;
            end
            pin_first   = 1'b1;
            resident[0] = 1'b1;
            use_clk     = 1;
            stamp[0]    = use_clk;
            hit_cnt     = '0;
            miss_cnt    = '0;
            r.fill       = 1'b1;
            r.fill_bytes = bytes_in_page(8'd0);
        end else if (23'(addr) >= rom_size) begin
            r.oor = 1'b1;
        end else begin
            r.offs = addr[13:0];
            for (int i = 0; i < SLOTS; i++) begin
                if (!found && resident[i] && page_of[i] == pg) begin
                    s     = i;
                    found = 1'b1;
                end
            end
            if (found) begin
                r.hit = 1'b1;
                hit_cnt++;
            end else begin
                s           = pick_victim();
                page_of[s]  = pg;
                resident[s] = 1'b1;
                miss_cnt++;
                r.fill       = 1'b1;
                r.fill_page  = pg;
                r.fill_bytes = bytes_in_page(pg);
            end
            use_clk++;
            stamp[s] = use_clk;
            r.slot   = 4'(s);
        end
        r.hits   = hit_cnt;
        r.misses = miss_cnt;
        return r;
    endfunction

    function automatic t_access random_access();
        t_access     a;
        int unsigned kind;
        int unsigned top_page;
        int unsigned span;
        bit [7:0]    pg;
        a.op  = OP_READ;
        kind  = $urandom_range(0, 99);
        top_page = (plan_size == 0) ? 0 : (32'(plan_size) - 1) >> 14;
        if (top_page > 255)
            top_page = 255;
        span = (top_page + 1 < 19) ? top_page + 1 : 19;
        if (kind < 2) begin
            a.op   = OP_RELOAD;
            a.addr = 22'($urandom);
        end else if (kind < 74) begin
            pg     = 8'(ws_base + $urandom_range(0, span));
            a.addr = {pg, 14'($urandom)};
        end else if (kind < 89) begin
            a.addr = 22'($urandom);
        end else begin
            a.addr = 22'(32'(plan_size) - 2 + $urandom_range(0, 3));
        end
        return a;
    endfunction

    task automatic push_req(t_op op, bit [21:0] addr);
        t_access a;
        a.op   = op;
        a.addr = addr;
        pending_reqs.push_back(a);
    endtask

    task automatic write_rom_size(bit [22:0] value);
        @(negedge i_clk);
        i_cfg_valid      <= 1'b1;
        i_rom_size_bytes <= value;
        do @(negedge i_clk); while (!cfg_taken);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (!(pending_reqs.size() == 0 && n_sent == n_taken
                 && expected_lookups.size() == 0))
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic run_phase(bit [22:0] size, int unsigned count, bit directed);
        int unsigned top_page;
        plan_size = size;
        top_page  = (size == 0) ? 0 : (32'(size) - 1) >> 14;
        if (top_page > 255)
            top_page = 255;
        ws_base = (top_page > 19) ? $urandom_range(0, top_page - 19) : 0;
        write_rom_size(size);
        if (directed) begin
            push_req(OP_READ, 22'd0);
            for (int p = 1; p < 15; p++)
                push_req(OP_READ, {8'(p), 14'($urandom)});
            push_req(OP_READ, 22'h3FFFFF);
            push_req(OP_READ, {8'd200, 14'h0000});
            push_req(OP_READ, {8'd1, 14'h3FFF});
            push_req(OP_READ, 22'd0);
            push_req(OP_RELOAD, 22'h3FFFFF);
            push_req(OP_READ, 22'h003FFF);
            push_req(OP_RELOAD, 22'd0);
            push_req(OP_READ, {8'd255, 14'h2AAA});
        end
        for (int n = 0; n < count; n++)
            pending_reqs.push_back(random_access());
        wait_drained();
    endtask

    always @(negedge i_clk) begin
        t_access a;
        if (i_rst_n && (!i_valid || req_taken)) begin
            if (i_valid)
                send_wait = draw_gap();
            if (send_wait == 0 && pending_reqs.size() != 0) begin
                a = pending_reqs.pop_front();
                n_sent++;
                i_op      <= a.op;
                i_address <= a.addr;
                i_valid   <= 1'b1;
            end else begin
                if (send_wait != 0)
                    send_wait--;
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (res_taken)
                take_wait = draw_gap();
            if (take_wait != 0) begin
                take_wait--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_lookup want;
        if (!i_rst_n) begin
            req_taken = 1'b0;
            res_taken = 1'b0;
            cfg_taken = 1'b0;
        end else begin
            res_taken = o_valid && i_ready;
            if (res_taken) begin
                if (expected_lookups.size() == 0) begin
                    report("result with no request outstanding");
                end else begin
                    want = expected_lookups.pop_front();
                    check_field("out_of_range", o_out_of_range, want.oor);
                    check_field("hit", o_hit, want.hit);
                    check_field("slot", o_slot, want.slot);
                    check_field("page_offset", o_page_offset, want.offs);
                    check_field("fill_request", o_fill_request, want.fill);
                    check_field("fill_page", o_fill_page, want.fill_page);
                    check_field("fill_valid_bytes", o_fill_valid_bytes, want.fill_bytes);
                    check_field("hit_total", o_hit_total, want.hits);
                    check_field("miss_total", o_miss_total, want.misses);
                end
            end
            cfg_taken = i_cfg_valid && o_cfg_ready;
            if (cfg_taken)
                rom_size = i_rom_size_bytes;
            req_taken = i_valid && o_ready;
            if (req_taken) begin
                expected_lookups.push_back(lookup_page(t_op'(i_op), i_address));
                n_taken++;
                if (n_taken % 64 == 0)
                    calm = ($urandom_range(0, 3) == 0);
            end
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        run_phase(23'd4194304, 150, 1'b1);
        run_phase(23'd32768, 140, 1'b0);
        run_phase(23'd50001, 130, 1'b0);
        run_phase(23'd0, 40, 1'b0);
        run_phase(23'h7FFFFF, 150, 1'b0);
        run_phase(23'($urandom_range(32768, 4194304)), 150, 1'b0);
        run_phase(23'd4194304, 150, 1'b0);
        run_phase(23'd32768, 110, 1'b0);
        if (n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
